FILE: rtl/uhk_pkg.sv
// ----------------------------------------------------------------------------
// uhk_pkg
// shared types, request codes and descriptor rom of the hid keyboard endpoint
// ----------------------------------------------------------------------------
package uhk_pkg;

  localparam int unsigned MaxPacket = 8;

  typedef enum logic [1:0] {
    KIND_OUT   = 2'd0,
    KIND_IN    = 2'd1,
    KIND_SETUP = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_ACK   = 2'd0,
    ST_NAK   = 2'd1,
    ST_STALL = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    DESC_DEVICE = 3'd0,
    DESC_CONFIG = 3'd1,
    DESC_LANG   = 3'd2,
    DESC_REPORT = 3'd3,
    DESC_STRING = 3'd4
  } desc_e;

  // request fields
  localparam logic [7:0] RT_STD_DEV_OUT = 8'h00;
  localparam logic [7:0] RT_STD_EP_OUT  = 8'h02;
  localparam logic [7:0] RT_STD_DEV_IN  = 8'h80;
  localparam logic [7:0] RT_STD_IF_IN   = 8'h81;
  localparam logic [7:0] RQ_CLEAR_FEATURE  = 8'h01;
  localparam logic [7:0] RQ_SET_ADDRESS    = 8'h05;
  localparam logic [7:0] RQ_GET_DESCRIPTOR = 8'h06;
  localparam logic [7:0] RQ_SET_CONFIG     = 8'h09;
  localparam logic [7:0] DT_DEVICE = 8'h01;
  localparam logic [7:0] DT_CONFIG = 8'h02;
  localparam logic [7:0] DT_STRING = 8'h03;
  localparam logic [7:0] DT_REPORT = 8'h22;

  // descriptor sizes and offsets in the main rom
  localparam logic [5:0] SIZE_DEVICE = 6'd18;
  localparam logic [5:0] SIZE_CONFIG = 6'd34;
  localparam logic [5:0] SIZE_LANG   = 6'd4;
  localparam logic [5:0] SIZE_REPORT = 6'd63;
  localparam logic [6:0] OFS_DEVICE  = 7'd0;
  localparam logic [6:0] OFS_CONFIG  = 7'd18;
  localparam logic [6:0] OFS_LANG    = 7'd52;
  localparam logic [6:0] OFS_REPORT  = 7'd56;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  endpoint;
    logic [63:0] payload;
    logic [3:0]  byte_count;
  } in_req_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  moved_count;
    logic [63:0] reply_data;
    logic [7:0]  current_address;
  } out_rsp_t;

  localparam logic [7:0] ROM_MAIN [128] = '{
    // device
    8'd18, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h08, 8'h6b, 8'h1d, 8'h04, 8'h01,
    8'h01, 8'h01, 8'h01, 8'h02, 8'h00, 8'h01,
    // configuration, interface, hid, endpoint
    8'h09, 8'h02, 8'd34, 8'h00, 8'h01, 8'h01, 8'h03, 8'ha0, 8'h00,
    8'h09, 8'h04, 8'h00, 8'h00, 8'h01, 8'h03, 8'h01, 8'h01, 8'h04,
    8'h09, 8'h21, 8'h11, 8'h01, 8'h21, 8'h01, 8'h22, 8'h3f, 8'h00,
    8'h07, 8'h05, 8'h81, 8'h03, 8'h08, 8'h00, 8'h02,
    // language list
    8'h04, 8'h03, 8'h09, 8'h04,
    // report
    8'h05, 8'h01, 8'h09, 8'h06, 8'hA1, 8'h01, 8'h05, 8'h07, 8'h19, 8'hE0, 8'h29, 8'hE7,
    8'h15, 8'h00, 8'h25, 8'h01, 8'h75, 8'h01, 8'h95, 8'h08, 8'h81, 8'h02, 8'h95, 8'h01,
    8'h75, 8'h08, 8'h81, 8'h01, 8'h95, 8'h05, 8'h75, 8'h01, 8'h05, 8'h08, 8'h19, 8'h01,
    8'h29, 8'h05, 8'h91, 8'h02, 8'h95, 8'h01, 8'h75, 8'h03, 8'h91, 8'h01, 8'h95, 8'h06,
    8'h75, 8'h08, 8'h15, 8'h00, 8'h25, 8'h65, 8'h05, 8'h07, 8'h19, 8'h00, 8'h29, 8'h65,
    8'h81, 8'h00, 8'hC0,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [7:0] ROM_TEXT [64] = '{
    8'h43, 8'h6f, 8'h72, 8'h65, 8'h6c, 8'h6c, 8'h69, 8'h75, 8'h6d,
    8'h4b, 8'h65, 8'h79, 8'h62, 8'h6f, 8'h61, 8'h72, 8'h64,
    8'h4b, 8'h65, 8'h79, 8'h62, 8'h6f, 8'h61, 8'h72, 8'h64,
    8'h48, 8'h49, 8'h44, 8'h20, 8'h44, 8'h65, 8'h76, 8'h69, 8'h63, 8'h65,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [5:0] TEXT_START [8] = '{6'd0, 6'd0, 6'd9, 6'd17, 6'd25, 6'd0, 6'd0, 6'd0};
  localparam logic [5:0] TEXT_LEN   [8] = '{6'd0, 6'd9, 6'd8, 6'd8, 6'd10, 6'd0, 6'd0, 6'd0};

  // full size of string descriptor sidx
  function automatic logic [5:0] string_size(logic [2:0] sidx);
    return {TEXT_LEN[sidx][4:0], 1'b0} + 6'd2;
  endfunction

  // byte k of the selected descriptor
  function automatic logic [7:0] desc_byte(desc_e sel, logic [2:0] sidx, logic [5:0] k);
    logic [5:0] half;
    logic [5:0] t;
    logic [7:0] b;
    half = (k - 6'd2) >> 1;
    t    = TEXT_START[sidx] + half;
    b    = '0;
    case (sel)
      DESC_DEVICE: b = ROM_MAIN[OFS_DEVICE + {1'b0, k}];
      DESC_CONFIG: b = ROM_MAIN[OFS_CONFIG + {1'b0, k}];
      DESC_LANG:   b = ROM_MAIN[OFS_LANG + {1'b0, k}];
      DESC_REPORT: b = ROM_MAIN[OFS_REPORT + {1'b0, k}];
      DESC_STRING: begin
        if (k == 6'd0) begin
          b = {2'b00, string_size(sidx)};
        end else if (k == 6'd1) begin
          b = DT_STRING;
        end else if (k[0]) begin
          b = 8'h00;
        end else begin
          b = ROM_TEXT[t];
        end
      end
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/uhk_ram.sv
// ----------------------------------------------------------------------------
// uhk_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module uhk_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/usb_hid_keyboard_endpoint.sv
// ----------------------------------------------------------------------------
// usb_hid_keyboard_endpoint
// device side of a full-speed hid keyboard: control endpoint zero sequencer
// ----------------------------------------------------------------------------
//  channel | dir | handshake                | payload
//  in      | in  | in_valid_i / in_ready_o  | in_req_i  (kind, endpoint, payload, byte_count)
//  out     | out | out_valid_o / out_ready_i| out_rsp_o (status, moved_count, reply_data,
//          |     |                          |            current_address)
//
//  a request is decoded in the cycle it is taken; a byte-wide sequencer then
//  moves data through the stage buffer ram one byte per cycle for descriptor
//  loads (n <= 63 bytes) and out packets; an in packet reads each byte in
//  S_INRD and captures it in S_INCAP, since the ram read is registered; a
//  request that moves no bytes goes straight from decode to S_DONE
//  in_ready_o is high only while the sequencer is idle; a finished response
//  waits in the output register and the next request is taken meanwhile
//  reset clears all control state; the buffer has no clearing pass, since an
//  in data stage only reads bytes that its own setup just loaded
// ----------------------------------------------------------------------------
module usb_hid_keyboard_endpoint #(
  parameter int unsigned BUF_DEPTH = 512
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  uhk_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output uhk_pkg::out_rsp_t out_rsp_o
);

  localparam int unsigned AW = $clog2(BUF_DEPTH);
  localparam int unsigned LW = $clog2(BUF_DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_OUTW  = 6'b000100,
    S_INRD  = 6'b001000,
    S_INCAP = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // control transfer state
  logic [7:0]    dev_addr_q, dev_addr_d;
  logic          setup_q, setup_d;
  logic [7:0]    rtype_q, rtype_d;
  logic [7:0]    rcode_q, rcode_d;
  logic [15:0]   rvalue_q, rvalue_d;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] ptr_q, ptr_d;

  // per-request working registers
  uhk_pkg::desc_e   sel_q, sel_d;
  logic [2:0]       sidx_q, sidx_d;
  logic [5:0]       k_q, k_d;
  logic [2:0]       j_q, j_d;
  logic [3:0]       step_q, step_d;
  logic [63:0]      pay_q, pay_d;
  logic [63:0]      data_q, data_d;
  uhk_pkg::status_e res_st_q, res_st_d;
  logic [3:0]       res_mv_q, res_mv_d;

  logic              out_valid_q, out_valid_d;
  uhk_pkg::out_rsp_t out_rsp_q, out_rsp_d;

  // ram port
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  // decode helpers on the incoming request
  logic       accept;
  logic [3:0] count;
  logic [15:0] wlen;
  logic [LW-1:0] wlen_sat;
  logic [LW-1:0] remain;
  logic [3:0]  avail;
  logic [7:0]  p_type, p_code, p_dtype, p_sidx8;
  logic        serve_ok;
  uhk_pkg::desc_e serve_sel;
  logic [5:0]  serve_size;
  logic [5:0]  serve_n;

  assign accept = in_valid_i && in_ready_o;
  assign count  = (in_req_i.byte_count > 4'(uhk_pkg::MaxPacket)) ?
                  4'(uhk_pkg::MaxPacket) : in_req_i.byte_count;
  assign wlen   = in_req_i.payload[63:48];
  assign wlen_sat = (32'(wlen) < BUF_DEPTH) ? LW'(wlen) : LW'(BUF_DEPTH);
  assign remain = len_q - ptr_q;
  assign avail  = (remain < LW'(count)) ? 4'(remain) : count;

  assign p_type  = in_req_i.payload[7:0];
  assign p_code  = in_req_i.payload[15:8];
  assign p_sidx8 = in_req_i.payload[23:16];
  assign p_dtype = in_req_i.payload[31:24];

  // which descriptor a get_descriptor asks for
  always_comb begin
    serve_ok   = 1'b0;
    serve_sel  = uhk_pkg::DESC_DEVICE;
    serve_size = uhk_pkg::SIZE_DEVICE;
    if (p_code == uhk_pkg::RQ_GET_DESCRIPTOR) begin
      if (p_type == uhk_pkg::RT_STD_DEV_IN) begin
        if (p_dtype == uhk_pkg::DT_DEVICE) begin
          serve_ok = 1'b1;
        end else if (p_dtype == uhk_pkg::DT_CONFIG) begin
          serve_ok   = 1'b1;
          serve_sel  = uhk_pkg::DESC_CONFIG;
          serve_size = uhk_pkg::SIZE_CONFIG;
        end else if (p_dtype == uhk_pkg::DT_STRING) begin
          if (p_sidx8 == 8'd0) begin
            serve_ok   = 1'b1;
            serve_sel  = uhk_pkg::DESC_LANG;
            serve_size = uhk_pkg::SIZE_LANG;
          end else if (p_sidx8 < 8'd5) begin
            serve_ok   = 1'b1;
            serve_sel  = uhk_pkg::DESC_STRING;
            serve_size = uhk_pkg::string_size(p_sidx8[2:0]);
          end
        end
      end else if (p_type == uhk_pkg::RT_STD_IF_IN && p_dtype == uhk_pkg::DT_REPORT) begin
        serve_ok   = 1'b1;
        serve_sel  = uhk_pkg::DESC_REPORT;
        serve_size = uhk_pkg::SIZE_REPORT;
      end
    end
  end

  // descriptors are all shorter than 64 bytes
  assign serve_n = (wlen < 16'(serve_size)) ? wlen[5:0] : serve_size;

  assign in_ready_o = (state_q == S_IDLE);

  // sequencer
  always_comb begin
    state_d    = state_q;
    dev_addr_d = dev_addr_q;
    setup_d    = setup_q;
    rtype_d    = rtype_q;
    rcode_d    = rcode_q;
    rvalue_d   = rvalue_q;
    len_d      = len_q;
    ptr_d      = ptr_q;
    sel_d      = sel_q;
    sidx_d     = sidx_q;
    k_d        = k_q;
    j_d        = j_q;
    step_d     = step_q;
    pay_d      = pay_q;
    data_d     = data_q;
    res_st_d   = res_st_q;
    res_mv_d   = res_mv_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_rsp_d   = out_rsp_q;
    ram_we     = 1'b0;
    ram_waddr  = ptr_q[AW-1:0];
    ram_wdata  = pay_q[{j_q, 3'b000} +: 8];
    ram_raddr  = ptr_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d  = S_DONE;
          pay_d    = in_req_i.payload;
          data_d   = '0;
          j_d      = '0;
          k_d      = '0;
          res_st_d = uhk_pkg::ST_NAK;
          res_mv_d = '0;
          if (in_req_i.endpoint != 4'd0) begin
            res_st_d = uhk_pkg::ST_NAK;
          end else if (in_req_i.kind == uhk_pkg::KIND_SETUP) begin
            rtype_d  = p_type;
            rcode_d  = p_code;
            rvalue_d = in_req_i.payload[31:16];
            ptr_d    = '0;
            len_d    = wlen_sat;
            setup_d  = 1'b1;
            res_st_d = uhk_pkg::ST_ACK;
            res_mv_d = count;
            if (p_type[7]) begin
              if (serve_ok) begin
                sel_d  = serve_sel;
                sidx_d = p_sidx8[2:0];
                len_d  = LW'(serve_n);
                if (serve_n != 6'd0) begin
                  state_d = S_LOAD;
                end
              end else begin
                setup_d  = 1'b0;
                res_st_d = uhk_pkg::ST_STALL;
                res_mv_d = '0;
              end
            end
          end else if (in_req_i.kind == uhk_pkg::KIND_OUT) begin
            if (!setup_q) begin
              res_st_d = uhk_pkg::ST_STALL;
            end else if (rtype_q[7]) begin
              // status stage of a device-to-host transfer
              setup_d  = 1'b0;
              res_st_d = uhk_pkg::ST_ACK;
              res_mv_d = count;
            end else begin
              res_st_d = uhk_pkg::ST_ACK;
              res_mv_d = avail;
              step_d   = avail;
              if (avail != 4'd0) begin
                state_d = S_OUTW;
              end
            end
          end else if (in_req_i.kind == uhk_pkg::KIND_IN) begin
            if (!setup_q) begin
              res_st_d = uhk_pkg::ST_STALL;
            end else if (!rtype_q[7]) begin
              // status stage: carry out the host-to-device request
              setup_d  = 1'b0;
              res_st_d = uhk_pkg::ST_STALL;
              if (rtype_q == uhk_pkg::RT_STD_DEV_OUT) begin
                if (rcode_q == uhk_pkg::RQ_SET_ADDRESS) begin
                  dev_addr_d = rvalue_q[7:0];
                  res_st_d   = uhk_pkg::ST_ACK;
                end else if (rcode_q == uhk_pkg::RQ_SET_CONFIG) begin
                  res_st_d = uhk_pkg::ST_ACK;
                end
              end else if (rtype_q == uhk_pkg::RT_STD_EP_OUT &&
                           rcode_q == uhk_pkg::RQ_CLEAR_FEATURE) begin
                res_st_d = uhk_pkg::ST_ACK;
              end
            end else begin
              res_st_d = uhk_pkg::ST_ACK;
              res_mv_d = avail;
              step_d   = avail;
              if (avail != 4'd0) begin
                state_d = S_INRD;
              end
            end
          end
        end
      end

      S_LOAD: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(k_q);
        ram_wdata = uhk_pkg::desc_byte(sel_q, sidx_q, k_q);
        k_d       = k_q + 6'd1;
        if (LW'(k_q) == len_q - LW'(1)) begin
          state_d = S_DONE;
        end
      end

      S_OUTW: begin
        ram_we = 1'b1;
        ptr_d  = ptr_q + LW'(1);
        j_d    = j_q + 3'd1;
        if ({1'b0, j_q} == step_q - 4'd1) begin
          state_d = S_DONE;
        end
      end

      S_INRD: begin
        state_d = S_INCAP;
      end

      S_INCAP: begin
        data_d[{j_q, 3'b000} +: 8] = ram_rdata;
        ptr_d = ptr_q + LW'(1);
        j_d   = j_q + 3'd1;
        if ({1'b0, j_q} == step_q - 4'd1) begin
          state_d = S_DONE;
        end else begin
          state_d = S_INRD;
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_rsp_d.status          = res_st_q;
          out_rsp_d.moved_count     = res_mv_q;
          out_rsp_d.reply_data      = data_q;
          out_rsp_d.current_address = dev_addr_q;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dev_addr_q  <= '0;
      setup_q     <= 1'b0;
      rtype_q     <= '0;
      rcode_q     <= '0;
      rvalue_q    <= '0;
      len_q       <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dev_addr_q  <= dev_addr_d;
      setup_q     <= setup_d;
      rtype_q     <= rtype_d;
      rcode_q     <= rcode_d;
      rvalue_q    <= rvalue_d;
      len_q       <= len_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sel_q     <= sel_d;
    sidx_q    <= sidx_d;
    k_q       <= k_d;
    j_q       <= j_d;
    step_q    <= step_d;
    pay_q     <= pay_d;
    data_q    <= data_d;
    res_st_q  <= res_st_d;
    res_mv_q  <= res_mv_d;
    out_rsp_q <= out_rsp_d;
  end

  // stage buffer
  uhk_ram #(
    .Width(8),
    .Depth(BUF_DEPTH)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // pointer never runs past the data stage length
  assert property (@(posedge clk_i) disable iff (!rst_ni) ptr_q <= len_q)
    else $error("stage pointer beyond stage length");

  // non-ack responses carry no bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status != uhk_pkg::ST_ACK |->
      out_rsp_o.moved_count == 4'd0 && out_rsp_o.reply_data == 64'd0)
    else $error("nak or stall with data");

  // descriptor load only runs for an open transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOAD |-> setup_q && rtype_q[7])
    else $error("load without open in transfer");

  // a taken request always closes the idle window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after a request");

endmodule
